@@ hw/rtl/gmm_bs_pkg.sv @@
// ----------------------------------------------------------------------------
// gmm_bs_pkg - shared types and constants
// Field widths, model record layout, pipeline context and config codes.
// ----------------------------------------------------------------------------
package gmm_bs_pkg;

    localparam int NUM_PIXELS_DEF = 76800;
    localparam int NUM_MODELS     = 2;

    localparam int PIX_W   = 8;
    localparam int IDX_W   = 17;
    localparam int FG_W    = 8;
    localparam int MEAN_W  = 16;
    localparam int VAR_W   = 25;
    localparam int WGT_W   = 18;
    localparam int CNT_W   = 8;
    localparam int Q_W     = 32;   // quotient of the rate divider
    localparam int DEN_W   = 17;   // divisor: positive weight or match count

    localparam int DIV_STEPS  = 2;                 // quotient bits per stage
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_VAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIALIZE   = 2'd3;

    localparam logic [15:0] LEARN_RATE_RST   = 16'd262;
    localparam logic [15:0] REPLACE_VAR_RST  = 16'd18000;
    localparam logic [15:0] BG_THRESHOLD_RST = 16'd45875;

    localparam logic [FG_W-1:0] FG_ON  = 8'd255;
    localparam logic [FG_W-1:0] FG_OFF = 8'd0;

    localparam logic signed [WGT_W-1:0] NEW_WGT_DEF = 18'sd13107;  // 0.2
    localparam logic [CNT_W-1:0]        CNT_MAX     = 8'd255;

    typedef struct packed {
        logic [MEAN_W-1:0]        mean;
        logic [VAR_W-1:0]         variance;
        logic signed [WGT_W-1:0]  weight;
        logic [CNT_W-1:0]         cnt;
        logic                     flag;
    } model_t;

    typedef model_t [NUM_MODELS-1:0] entry_t;

    localparam model_t INIT_MODEL = '{
        mean: 16'd0, variance: 25'd1254400, weight: 18'sd5898, cnt: 8'd0, flag: 1'b1
    };
    localparam model_t CLEAR_MODEL = '{
        mean: 16'd0, variance: 25'd0, weight: 18'sd0, cnt: 8'd0, flag: 1'b1
    };

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] replace_variance;
        logic [15:0] bg_threshold;
        logic        initialize;
    } cfg_t;

    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
    } req_t;

    typedef struct packed {
        req_t   req;
        entry_t mdl;
        logic   matched;
        logic   sel;      // best match, or model to replace
        logic   first;    // fitter model before update
        logic   nzero;    // other model's match count is zero
    } ctx_t;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic [IDX_W-1:0] idx;
        entry_t           mdl;
        logic [FG_W-1:0]  fg;
    } wb_t;

endpackage

@@ hw/rtl/gmm_bs_mem.sv @@
// ----------------------------------------------------------------------------
// gmm_bs_mem - per-pixel model store
// One entry per pixel holding both models; registered read, one write port.
// ----------------------------------------------------------------------------
module gmm_bs_mem import gmm_bs_pkg::*; #(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF,
    localparam int ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [NUM_PIXELS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/gmm_bs_front.sv @@
// ----------------------------------------------------------------------------
// gmm_bs_front - match test and model selection
// Distance and fitness products, then match, best/worst choice and divider
// operands.
// ----------------------------------------------------------------------------
module gmm_bs_front import gmm_bs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  req_t             in_req,
    input  entry_t           rd_data,
    input  logic [IDX_W-1:0] probe_idx,
    output logic             out_valid,
    output ctx_t             out_ctx,
    output logic [Q_W-1:0]   out_num,
    output logic [DEN_W-1:0] out_den,
    output logic             hit
);

    entry_t                ent;
    logic [MEAN_W-1:0]     px;
    logic signed [17:0]    d    [NUM_MODELS];
    logic signed [35:0]    dd   [NUM_MODELS];
    logic [35:0]           vlim [NUM_MODELS];
    logic [VAR_W-1:0]      ve   [NUM_MODELS];
    logic signed [43:0]    fa_c, fb_c;

    logic                  f1_valid_reg;
    req_t                  f1_req_reg;
    entry_t                f1_ent_reg;
    logic [31:0]           f1_sqd_reg  [NUM_MODELS];
    logic [35:0]           f1_vlim_reg [NUM_MODELS];
    logic signed [43:0]    f1_fa_reg, f1_fb_reg;

    logic m0, m1, b0, b1, fa_gt, fb_gt, matched, sel, nzero;
    logic [CNT_W-1:0] n;

    always_comb begin
        ent = cfg.initialize ? {NUM_MODELS{INIT_MODEL}} : rd_data;
        px  = {in_req.pix, 8'd0};
        for (int k = 0; k < NUM_MODELS; k++) begin
            d[k]    = $signed({2'b00, px}) - $signed({2'b00, ent[k].mean});
            dd[k]   = d[k] * d[k];
            vlim[k] = 36'(ent[k].variance) * 36'd1600;
            ve[k]   = (ent[k].variance == '0) ? VAR_W'(1) : ent[k].variance;
        end
        // w1*ve0 > w0*ve1 means model 1 is fitter
        fa_c = $signed(ent[1].weight) * $signed({1'b0, ve[0]});
        fb_c = $signed(ent[0].weight) * $signed({1'b0, ve[1]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_req_reg <= in_req;
            f1_ent_reg <= ent;
            f1_fa_reg  <= fa_c;
            f1_fb_reg  <= fb_c;
            for (int k = 0; k < NUM_MODELS; k++) begin
                f1_sqd_reg[k]  <= dd[k][31:0];
                f1_vlim_reg[k] <= vlim[k];
            end
        end
    end

    always_comb begin
        m0      = f1_ent_reg[0].flag && ({4'd0, f1_sqd_reg[0]} < f1_vlim_reg[0]);
        m1      = f1_ent_reg[1].flag && ({4'd0, f1_sqd_reg[1]} < f1_vlim_reg[1]);
        fa_gt   = f1_fa_reg > f1_fb_reg;
        fb_gt   = f1_fb_reg > f1_fa_reg;
        b0      = m0 && ($signed(f1_ent_reg[0].weight) > 18'sd0);
        b1      = m1 && ($signed(f1_ent_reg[1].weight) > 18'sd0) && (!b0 || fa_gt);
        matched = b0 || b1;
        sel     = b1 || (!matched && fb_gt);
        n       = f1_ent_reg[~sel].cnt;
        nzero   = (n == '0);

        out_valid       = f1_valid_reg;
        out_ctx.req     = f1_req_reg;
        out_ctx.mdl     = f1_ent_reg;
        out_ctx.matched = matched;
        out_ctx.sel     = sel;
        out_ctx.first   = fa_gt;
        out_ctx.nzero   = nzero;

        // matched: alpha/weight rate; no match: round(1/n) for the new weight
        if (matched) begin
            out_num = {cfg.learn_rate, 16'd0};
            out_den = f1_ent_reg[sel].weight[DEN_W-1:0];
        end else begin
            out_num = 32'd65536 + 32'(n[CNT_W-1:1]);
            out_den = nzero ? DEN_W'(1) : DEN_W'(n);
        end

        hit = f1_valid_reg && (f1_req_reg.idx == probe_idx);
    end

endmodule

@@ hw/rtl/gmm_bs_div.sv @@
// ----------------------------------------------------------------------------
// gmm_bs_div - pipelined restoring divider
// Unsigned quotient, two bits per stage; request context rides alongside.
// ----------------------------------------------------------------------------
module gmm_bs_div import gmm_bs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  ctx_t             in_ctx,
    input  logic [Q_W-1:0]   in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [IDX_W-1:0] probe_idx,
    output logic             out_valid,
    output ctx_t             out_ctx,
    output logic [Q_W-1:0]   out_q,
    output logic             hit
);

    logic             valid_reg [DIV_STAGES];
    ctx_t             ctx_reg   [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg   [DIV_STAGES];
    logic [DEN_W-1:0] den_reg   [DIV_STAGES];
    logic [Q_W-1:0]   num_reg   [DIV_STAGES];
    logic [DEN_W-1:0] rem_next  [DIV_STAGES];
    logic [Q_W-1:0]   num_next  [DIV_STAGES];

    always_comb begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        logic [DEN_W-1:0] dv;
        logic [Q_W-1:0]   nq;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                r  = '0;
                nq = in_num;
                dv = in_den;
            end else begin
                r  = rem_reg[s-1];
                nq = num_reg[s-1];
                dv = den_reg[s-1];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                t = {r, nq[Q_W-1]};
                if (t >= {1'b0, dv}) begin
                    r  = DEN_W'(t - {1'b0, dv});
                    nq = {nq[Q_W-2:0], 1'b1};
                end else begin
                    r  = t[DEN_W-1:0];
                    nq = {nq[Q_W-2:0], 1'b0};
                end
            end
            rem_next[s] = r;
            num_next[s] = nq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STAGES; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_ctx;
            den_reg[0] <= in_den;
            for (int s = 1; s < DIV_STAGES; s++) begin
                ctx_reg[s] <= ctx_reg[s-1];
                den_reg[s] <= den_reg[s-1];
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
            end
        end
    end

    always_comb begin
        out_valid = valid_reg[DIV_STAGES-1];
        out_ctx   = ctx_reg[DIV_STAGES-1];
        out_q     = num_reg[DIV_STAGES-1];
        hit       = 1'b0;
        for (int s = 0; s < DIV_STAGES; s++) begin
            hit = hit | (valid_reg[s] && (ctx_reg[s].req.idx == probe_idx));
        end
    end

endmodule

@@ hw/rtl/gmm_bs_back.sv @@
// ----------------------------------------------------------------------------
// gmm_bs_back - model update and write-back record
// Mean, variance and weight update, decay, replacement and flag rebuild.
// ----------------------------------------------------------------------------
module gmm_bs_back import gmm_bs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  ctx_t             in_ctx,
    input  logic [Q_W-1:0]   in_q,
    input  logic [IDX_W-1:0] probe_idx,
    output wb_t              wb,
    output logic             hit
);

    localparam int NST = 5;

    logic               valid_reg [NST];
    ctx_t               ctx_reg   [NST];
    logic [Q_W-1:0]     q_reg     [NST];
    logic signed [50:0] p1_reg;
    logic [MEAN_W-1:0]  nm2_reg, nm3_reg, nm4_reg, nm5_reg;
    logic [31:0]        sqr3_reg;
    logic signed [26:0] diff4_reg;
    logic signed [59:0] p2_reg;
    logic signed [35:0] p3_reg;
    wb_t                wb_reg;

    model_t             mdl1, mdl2, mdl4, mdl5;
    logic [MEAN_W-1:0]  px1, px3;
    logic signed [17:0] ds1, d3;
    logic signed [50:0] p1_c, t2, s2;
    logic [MEAN_W-1:0]  nm_c;
    logic signed [35:0] sq3;
    logic [VAR_W-1:0]   sq4;
    logic signed [26:0] diff_c;
    logic signed [59:0] p2_c;
    logic signed [18:0] t5;
    logic signed [35:0] p3_c;

    ctx_t               c6;
    logic               sel6, oth6;
    logic signed [59:0] tv, sv;
    logic signed [35:0] tw, sw;
    logic signed [18:0] so;
    logic [VAR_W-1:0]   nv;
    logic signed [WGT_W-1:0] nw, wo, wf;
    entry_t             nxt;
    wb_t                wb_next;

    // B1: rate times mean error
    always_comb begin
        mdl1 = in_ctx.mdl[in_ctx.sel];
        px1  = {in_ctx.req.pix, 8'd0};
        ds1  = $signed({2'b00, px1}) - $signed({2'b00, mdl1.mean});
        p1_c = $signed({1'b0, in_q}) * ds1;
    end

    // B2: new mean
    always_comb begin
        mdl2 = ctx_reg[0].mdl[ctx_reg[0].sel];
        t2   = (p1_reg + 51'sd32768) >>> 16;
        s2   = t2 + $signed(51'(mdl2.mean));
        if (s2 < 51'sd0) begin
            nm_c = '0;
        end else if (s2 > 51'sd65535) begin
            nm_c = '1;
        end else begin
            nm_c = s2[MEAN_W-1:0];
        end
    end

    // B3: squared error against new mean
    always_comb begin
        px3 = {ctx_reg[1].req.pix, 8'd0};
        d3  = $signed({2'b00, px3}) - $signed({2'b00, nm2_reg});
        sq3 = d3 * d3;
    end

    // B4: variance error
    always_comb begin
        mdl4   = ctx_reg[2].mdl[ctx_reg[2].sel];
        sq4    = VAR_W'((33'(sqr3_reg) + 33'd128) >> 8);
        diff_c = $signed(27'(sq4)) - $signed(27'(mdl4.variance));
    end

    // B5: variance and weight products
    always_comb begin
        mdl5 = ctx_reg[3].mdl[ctx_reg[3].sel];
        p2_c = $signed({1'b0, q_reg[3]}) * diff4_reg;
        t5   = 19'sd65536 - $signed({mdl5.weight[WGT_W-1], mdl5.weight});
        p3_c = $signed({1'b0, cfg.learn_rate}) * t5;
    end

    // B6: compose the new entry
    always_comb begin
        c6   = ctx_reg[4];
        sel6 = c6.sel;
        oth6 = ~c6.sel;

        tv = (p2_reg + 60'sd32768) >>> 16;
        sv = tv + $signed(60'(c6.mdl[sel6].variance));
        if (sv < 60'sd0) begin
            nv = '0;
        end else if (sv > 60'sd33554431) begin
            nv = '1;
        end else begin
            nv = sv[VAR_W-1:0];
        end

        tw = (p3_reg + 36'sd32768) >>> 16;
        sw = tw + 36'($signed(c6.mdl[sel6].weight));
        if (sw > 36'sd131071) begin
            nw = 18'sd131071;
        end else if (sw < -36'sd131072) begin
            nw = -18'sd131072;
        end else begin
            nw = sw[WGT_W-1:0];
        end

        so = $signed({c6.mdl[oth6].weight[WGT_W-1], c6.mdl[oth6].weight})
             - $signed({3'b000, cfg.learn_rate});
        wo = (so < -19'sd131072) ? -18'sd131072 : so[WGT_W-1:0];

        nxt = c6.mdl;
        nxt[oth6].weight = wo;
        if (c6.matched) begin
            nxt[sel6].mean     = nm5_reg;
            nxt[sel6].variance = nv;
            nxt[sel6].weight   = nw;
            if (c6.mdl[sel6].cnt != CNT_MAX) begin
                nxt[sel6].cnt = c6.mdl[sel6].cnt + 8'd1;
            end
            // flags by fitness order before the update, new weights
            wf = nxt[c6.first].weight;
            nxt[0].flag = 1'b0;
            nxt[1].flag = 1'b0;
            nxt[c6.first].flag  = 1'b1;
            nxt[~c6.first].flag = (wf < $signed({2'b00, cfg.bg_threshold}));
        end else begin
            wf = '0;
            nxt[sel6].mean     = {c6.req.pix, 8'd0};
            nxt[sel6].variance = {1'b0, cfg.replace_variance, 8'd0};
            nxt[sel6].cnt      = 8'd1;
            nxt[sel6].weight   = c6.nzero ? NEW_WGT_DEF : q_reg[4][WGT_W-1:0];
        end

        wb_next.valid    = valid_reg[4];
        wb_next.in_range = c6.req.in_range;
        wb_next.idx      = c6.req.idx;
        wb_next.mdl      = nxt;
        wb_next.fg       = (c6.req.in_range && !c6.matched) ? FG_ON : FG_OFF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NST; s++) begin
                valid_reg[s] <= 1'b0;
            end
            wb_reg.valid <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
            wb_reg.valid <= wb_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_ctx;
            q_reg[0]   <= in_q;
            for (int s = 1; s < NST; s++) begin
                ctx_reg[s] <= ctx_reg[s-1];
                q_reg[s]   <= q_reg[s-1];
            end
            p1_reg          <= p1_c;
            nm2_reg         <= nm_c;
            nm3_reg         <= nm2_reg;
            sqr3_reg        <= sq3[31:0];
            nm4_reg         <= nm3_reg;
            diff4_reg       <= diff_c;
            nm5_reg         <= nm4_reg;
            p2_reg          <= p2_c;
            p3_reg          <= p3_c;
            wb_reg.in_range <= wb_next.in_range;
            wb_reg.idx      <= wb_next.idx;
            wb_reg.mdl      <= wb_next.mdl;
            wb_reg.fg       <= wb_next.fg;
        end
    end

    always_comb begin
        wb  = wb_reg;
        hit = wb_reg.valid && (wb_reg.idx == probe_idx);
        for (int s = 0; s < NST; s++) begin
            hit = hit | (valid_reg[s] && (ctx_reg[s].req.idx == probe_idx));
        end
    end

endmodule

@@ hw/rtl/gmm_background_subtraction_core.sv @@
// ----------------------------------------------------------------------------
// gmm_background_subtraction_core - two-model Gaussian mixture background
// subtraction, one grey pixel per request
// ----------------------------------------------------------------------------
// Each request carries a pixel and its frame index; the block answers with
// 255 (foreground, no model matched) or 0 (background, or index out of
// range). Both models of a pixel live in one memory word that is read when
// the request is taken and written back after a 16-stage pipelined divider
// forms the learning rate alpha/weight. Requests are taken one per cycle
// unless the output stalls or a pending same-pixel request holds them off.
// A request whose pixel index equals that of a request still in the
// pipeline is held off until that one has written back. After reset the
// block writes a cleared entry (zero match counts, background flags set)
// to every pixel, with s_ready low; config writes are taken throughout and
// must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module gmm_background_subtraction_core import gmm_bs_pkg::*; #(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // pixel requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    input  logic [IDX_W-1:0]      s_pixel_index,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FG_W-1:0]       m_foreground
);

    localparam int ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NUM_PIXELS - 1);

    cfg_t              cfg_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    req_t              s1_req_reg;
    logic              out_valid_reg;
    logic [FG_W-1:0]   out_fg_reg;

    logic              adv;          // whole pipeline moves one stage
    logic              s_in_range;
    logic              hazard;
    logic              s1_hit, f_hit, d_hit, b_hit;
    req_t              s_req;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    entry_t            mem_wdata;
    entry_t            mem_rdata;

    logic              f_valid;
    ctx_t              f_ctx;
    logic [Q_W-1:0]    f_num;
    logic [DEN_W-1:0]  f_den;
    logic              d_valid;
    ctx_t              d_ctx;
    logic [Q_W-1:0]    d_q;
    wb_t               wb;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.learn_rate       <= LEARN_RATE_RST;
            cfg_reg.replace_variance <= REPLACE_VAR_RST;
            cfg_reg.bg_threshold     <= BG_THRESHOLD_RST;
            cfg_reg.initialize       <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LEARN_RATE:   cfg_reg.learn_rate       <= cfg_wr_data;
                CFG_REPLACE_VAR:  cfg_reg.replace_variance <= cfg_wr_data;
                CFG_BG_THRESHOLD: cfg_reg.bg_threshold     <= cfg_wr_data;
                CFG_INITIALIZE:   cfg_reg.initialize       <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- clearing pass after reset ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == CLR_LAST) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // ---------------- flow control ----------------
    // stall only when a finished result would overrun a full output register
    assign adv        = !(wb.valid && out_valid_reg && !m_ready);
    assign s_in_range = (32'(s_pixel_index) < 32'(NUM_PIXELS));
    assign s1_hit     = s1_valid_reg && (s1_req_reg.idx == s_pixel_index);
    // same pixel still in flight: wait for its write-back
    assign hazard     = s1_hit || f_hit || d_hit || b_hit;
    assign s_ready    = adv && !clearing_reg && !hazard;

    assign s_req.in_range = s_in_range;
    assign s_req.idx      = s_pixel_index;
    assign s_req.pix      = s_pixel;

    // read issue stage; memory data lines up with s1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_req_reg <= s_req;
        end
    end

    // ---------------- model store ----------------
    assign mem_raddr = ADDR_W'(s_pixel_index);
    assign mem_we    = clearing_reg || (adv && wb.valid && wb.in_range);
    assign mem_waddr = clearing_reg ? clr_addr_reg : ADDR_W'(wb.idx);
    assign mem_wdata = clearing_reg ? {NUM_MODELS{CLEAR_MODEL}} : wb.mdl;

    gmm_bs_mem #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (adv),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- match and selection ----------------
    gmm_bs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_valid  (s1_valid_reg),
        .in_req    (s1_req_reg),
        .rd_data   (mem_rdata),
        .probe_idx (s_pixel_index),
        .out_valid (f_valid),
        .out_ctx   (f_ctx),
        .out_num   (f_num),
        .out_den   (f_den),
        .hit       (f_hit)
    );

    // ---------------- rate divider ----------------
    gmm_bs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (f_valid),
        .in_ctx    (f_ctx),
        .in_num    (f_num),
        .in_den    (f_den),
        .probe_idx (s_pixel_index),
        .out_valid (d_valid),
        .out_ctx   (d_ctx),
        .out_q     (d_q),
        .hit       (d_hit)
    );

    // ---------------- model update ----------------
    gmm_bs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .in_ctx    (d_ctx),
        .in_q      (d_q),
        .probe_idx (s_pixel_index),
        .wb        (wb),
        .hit       (b_hit)
    );

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && wb.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && wb.valid) begin
            out_fg_reg <= wb.fg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_foreground = out_fg_reg;

    // ---------------- assertions ----------------
    // a taken request never reads the entry being written back
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_in_range && mem_we) |-> (mem_waddr != mem_raddr))
        else $error("read of an entry under write-back");

    // clearing runs once after reset
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clearing_reg |=> !clearing_reg)
        else $error("clearing pass restarted");

    // no requests taken while clearing
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !(s_valid && s_ready))
        else $error("request taken during clearing");

    // a new result only comes from the write-back stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(wb.valid && adv))
        else $error("result without write-back");

endmodule
